// ===== rtl/mkt_pkg.sv =====
`timescale 1ns / 1ps
package mkt_pkg;

	localparam int DurW = 16;
	localparam int CharW = 8;
	localparam int SymMax = 4;
	localparam int LenW = 3;
	localparam int IdxW = 4;

	localparam logic [IdxW-1:0] REG_DOT = 4'd0;
	localparam logic [IdxW-1:0] REG_DASH = 4'd1;
	localparam logic [IdxW-1:0] REG_SYM_GAP = 4'd2;
	localparam logic [IdxW-1:0] REG_WORD_GAP = 4'd3;

	localparam logic [DurW-1:0] DOT_RST = 16'd300;
	localparam logic [DurW-1:0] DASH_RST = 16'd900;
	localparam logic [DurW-1:0] SYM_GAP_RST = 16'd1000;
	localparam logic [DurW-1:0] WORD_GAP_RST = 16'd2700;

	localparam logic [CharW-1:0] CH_SPACE = 8'h20;
	localparam logic [CharW-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CharW-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CharW-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CharW-1:0] CH_LOWER_Z = 8'h7A;

	typedef struct packed {
		logic [DurW-1:0] dot;
		logic [DurW-1:0] dash;
		logic [DurW-1:0] sym_gap;
		logic [DurW-1:0] word_gap;
	} cfg_t;

	typedef struct packed {
		logic [LenW-1:0]   len;
		logic [SymMax-1:0] pat;
	} code_t;

	function automatic code_t letter_code(input logic [4:0] idx);
		code_t c;
		logic [SymMax-1:0] raw;
		c.len = 3'd1;
		raw = 4'h0;
		unique case (idx)
			5'd0:  begin c.len = 3'd2; raw = 4'h1; end
			5'd1:  begin c.len = 3'd4; raw = 4'h8; end
			5'd2:  begin c.len = 3'd4; raw = 4'hA; end
			5'd3:  begin c.len = 3'd3; raw = 4'h4; end
			5'd4:  begin c.len = 3'd1; raw = 4'h0; end
			5'd5:  begin c.len = 3'd4; raw = 4'h2; end
			5'd6:  begin c.len = 3'd3; raw = 4'h6; end
			5'd7:  begin c.len = 3'd4; raw = 4'h0; end
			5'd8:  begin c.len = 3'd2; raw = 4'h0; end
			5'd9:  begin c.len = 3'd4; raw = 4'h7; end
			5'd10: begin c.len = 3'd3; raw = 4'h5; end
			5'd11: begin c.len = 3'd4; raw = 4'h4; end
			5'd12: begin c.len = 3'd2; raw = 4'h3; end
			5'd13: begin c.len = 3'd2; raw = 4'h2; end
			5'd14: begin c.len = 3'd3; raw = 4'h7; end
			5'd15: begin c.len = 3'd4; raw = 4'h6; end
			5'd16: begin c.len = 3'd4; raw = 4'hD; end
			5'd17: begin c.len = 3'd3; raw = 4'h2; end
			5'd18: begin c.len = 3'd3; raw = 4'h0; end
			5'd19: begin c.len = 3'd1; raw = 4'h1; end
			5'd20: begin c.len = 3'd3; raw = 4'h1; end
			5'd21: begin c.len = 3'd4; raw = 4'h1; end
			5'd22: begin c.len = 3'd3; raw = 4'h3; end
			5'd23: begin c.len = 3'd4; raw = 4'h9; end
			5'd24: begin c.len = 3'd4; raw = 4'hB; end
			5'd25: begin c.len = 3'd4; raw = 4'hC; end
			default: begin c.len = 3'd1; raw = 4'h0; end
		endcase
		// left-align so the first symbol sits in the top bit
		c.pat = raw << (3'd4 - c.len);
		return c;
	endfunction

endpackage

// ===== rtl/mkt_cfg_regs.sv =====
`timescale 1ns / 1ps
module mkt_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [mkt_pkg::IdxW-1:0] wr_index,
	input  logic [mkt_pkg::DurW-1:0] wr_data,
	output mkt_pkg::cfg_t            cfg
);
	import mkt_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot <= DOT_RST;
			cfg_q.dash <= DASH_RST;
			cfg_q.sym_gap <= SYM_GAP_RST;
			cfg_q.word_gap <= WORD_GAP_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DOT:      cfg_q.dot <= wr_data;
				REG_DASH:     cfg_q.dash <= wr_data;
				REG_SYM_GAP:  cfg_q.sym_gap <= wr_data;
				REG_WORD_GAP: cfg_q.word_gap <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/mkt_seq.sv =====
`timescale 1ns / 1ps
module mkt_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mkt_pkg::CharW-1:0] character,
	input  mkt_pkg::cfg_t             cfg,
	output logic                      busy,
	output logic                      strobe,
	output logic                      tone_on,
	output logic [mkt_pkg::DurW-1:0]  duration_ms,
	output logic                      last
);
	import mkt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_TONE = 4'b0010,
		ST_GAP  = 4'b0100,
		ST_WORD = 4'b1000
	} state_t;

	state_t            state_q;
	logic [SymMax-1:0] pat_q;
	logic [LenW-1:0]   rem_q;
	logic              strobe_q;
	logic              tone_q;
	logic [DurW-1:0]   dur_q;
	logic              last_q;

	logic              accept;
	logic              is_space;
	logic              is_upper;
	logic              is_lower;
	logic [CharW-1:0]  offset;
	logic [4:0]        idx;
	code_t             code;
	logic [DurW-1:0]   dur_sel;
	logic              last_sym;

	assign accept = start && (state_q == ST_IDLE);
	assign is_space = (character == CH_SPACE);
	assign is_upper = (character >= CH_UPPER_A) && (character <= CH_UPPER_Z);
	assign is_lower = (character >= CH_LOWER_A) && (character <= CH_LOWER_Z);
	assign offset = is_upper ? (character - CH_UPPER_A) : (character - CH_LOWER_A);
	assign idx = offset[4:0];
	assign code = letter_code(idx);
	assign last_sym = (rem_q == LenW'(1));

	// shared duration select
	always_comb begin
		unique case (state_q)
			ST_TONE: dur_sel = pat_q[SymMax-1] ? cfg.dash : cfg.dot;
			ST_GAP:  dur_sel = cfg.sym_gap;
			ST_WORD: dur_sel = cfg.word_gap;
			default: dur_sel = cfg.word_gap;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe_q <= 1'b0;
			rem_q <= '0;
		end else begin
			strobe_q <= (state_q != ST_IDLE);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_space) begin
						state_q <= ST_WORD;
					end else if (accept && (is_upper || is_lower)) begin
						state_q <= ST_TONE;
						rem_q <= code.len;
					end
				end
				ST_TONE: state_q <= ST_GAP;
				ST_GAP: begin
					rem_q <= rem_q - LenW'(1);
					state_q <= last_sym ? ST_IDLE : ST_TONE;
				end
				ST_WORD: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			pat_q <= code.pat;
		end else if (state_q == ST_GAP) begin
			pat_q <= pat_q << 1;
		end
		tone_q <= (state_q == ST_TONE);
		dur_q <= dur_sel;
		last_q <= (state_q == ST_WORD) || ((state_q == ST_GAP) && last_sym);
	end

	assign busy = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign tone_on = tone_q;
	assign duration_ms = dur_q;
	assign last = last_q;

endmodule

// ===== rtl/morse_keyer_timing.sv =====
`timescale 1ns / 1ps
// Morse keyer timing: turns one character byte into its keying schedule.
// Command channel: raise start with character; the item is taken at an edge
// where start is high and busy is low. Letters of either case and space are
// acted on; any other byte is taken and gives no result.
// Result channel: each interval appears on tone_on, duration_ms and last for
// one cycle, marked by strobe; last flags the final interval of a character.
// The receiver cannot hold results off.
// Results: the first result is registered from the state entered when the item
// is taken, then one result per cycle. A letter of n symbols gives 2n results;
// a space gives one result.
// One duration select and one symbol counter step through the letter, so a
// character gives at most eight results.
// Configuration: registers 0..3 (dot, dash, symbol gap, word gap, in ms) are
// written through cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high, indexes beyond 3 are dropped. Write only while idle.
// Reset: asynchronous, active low; returns to idle with durations 300, 900,
// 1000 and 2700 ms.
module morse_keyer_timing (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [mkt_pkg::CharW-1:0] character,
	output logic                      strobe,
	output logic                      tone_on,
	output logic [mkt_pkg::DurW-1:0]  duration_ms,
	output logic                      last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [mkt_pkg::IdxW-1:0]  cfg_index,
	input  logic [mkt_pkg::DurW-1:0]  cfg_data
);
	import mkt_pkg::*;

	cfg_t cfg;

	assign cfg_ready = 1'b1;

	mkt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	mkt_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.character   (character),
		.cfg         (cfg),
		.busy        (busy),
		.strobe      (strobe),
		.tone_on     (tone_on),
		.duration_ms (duration_ms),
		.last        (last)
	);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import mkt_pkg::*;

	localparam int SETTLE_CYC = 10;
	localparam int TIMEOUT_NS = 3_000_000;
	localparam int PHASE_ITEMS = 49;
	localparam logic [IdxW-1:0] REG_SPARE = 4'd9;
	localparam logic [IdxW-1:0] REG_TOP = {IdxW{1'b1}};

	typedef struct packed {
		logic            tone;
		logic [DurW-1:0] dur;
		logic            fin;
	} interval_t;

	typedef enum logic {ROW_CFG, ROW_CHAR} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [IdxW-1:0]  idx;
		logic [DurW-1:0]  data;
		logic [CharW-1:0] ch;
		logic             typed;
		logic [1:0]       n;
		interval_t        r0;
		interval_t        r1;
	} row_t;

	localparam interval_t NO_IVL = '0;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [CharW-1:0] character;
	logic             strobe;
	logic             tone_on;
	logic [DurW-1:0]  duration_ms;
	logic             last;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IdxW-1:0]  cfg_index;
	logic [DurW-1:0]  cfg_data;

	cfg_t      durs;
	interval_t schedule_q[$];
	interval_t want;
	row_t      dir_q[$];
	row_t      rw;
	bit        failed;
	int        idle_pct;
	int        acted;
	int        pick;
	int        sel;
	logic [CharW-1:0] ch;
	logic [DurW-1:0]  val;

	morse_keyer_timing u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.character  (character),
		.strobe     (strobe),
		.tone_on    (tone_on),
		.duration_ms(duration_ms),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic interval_t ivl(input logic tone, input logic [DurW-1:0] dur,
			input logic fin);
		ivl = {tone, dur, fin};
	endfunction

	function automatic row_t char_row(input logic [CharW-1:0] c, input logic typed,
			input logic [1:0] n, input interval_t r0, input interval_t r1);
		char_row = {ROW_CHAR, {IdxW{1'b0}}, {DurW{1'b0}}, c, typed, n, r0, r1};
	endfunction

	function automatic row_t cfg_row(input logic [IdxW-1:0] idx, input logic [DurW-1:0] d);
		cfg_row = {ROW_CFG, idx, d, {CharW{1'b0}}, 1'b0, 2'd0, NO_IVL, NO_IVL};
	endfunction

	// keying schedule of one character under the current durations
	function automatic void key_schedule(input logic [CharW-1:0] c);
		string code;
		logic [CharW-1:0] up;
		code = "";
		if (c == CH_SPACE) begin
			schedule_q.push_back(ivl(1'b0, durs.word_gap, 1'b1));
			return;
		end
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
			up = c;
		else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
			up = c - (CH_LOWER_A - CH_UPPER_A);
		else
			return;
		case (up)
			"A": code = ".-";   "B": code = "-..."; "C": code = "-.-."; "D": code = "-..";
			"E": code = ".";    "F": code = "..-."; "G": code = "--.";  "H": code = "....";
			"I": code = "..";   "J": code = ".---"; "K": code = "-.-";  "L": code = ".-..";
			"M": code = "--";   "N": code = "-.";   "O": code = "---";  "P": code = ".--.";
			"Q": code = "--.-"; "R": code = ".-.";  "S": code = "...";  "T": code = "-";
			"U": code = "..-";  "V": code = "...-"; "W": code = ".--";  "X": code = "-..-";
			"Y": code = "-.--"; "Z": code = "--..";
			default: code = "";
		endcase
		for (int i = 0; i < code.len(); i++) begin
			schedule_q.push_back(ivl(1'b1, (code[i] == "-") ? durs.dash : durs.dot, 1'b0));
			schedule_q.push_back(ivl(1'b0, durs.sym_gap, i == code.len() - 1));
		end
	endfunction

	function automatic void check_field(input string name, input logic [DurW-1:0] exp_v,
			input logic [DurW-1:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, got_v);
			failed = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (schedule_q.size() == 0) begin
				$display("%0t ns: interval expected none, got tone_on=%0b duration_ms=%0d last=%0b",
					$time, tone_on, duration_ms, last);
				failed = 1'b1;
			end else begin
				want = schedule_q.pop_front();
				check_field("tone_on", DurW'(want.tone), DurW'(tone_on));
				check_field("duration_ms", want.dur, duration_ms);
				check_field("last", DurW'(want.fin), DurW'(last));
			end
		end
	end

	task automatic send_char(input logic [CharW-1:0] c, input int gap_pct, input bit predict);
		@(negedge clk);
		while ($urandom_range(0, 99) < gap_pct) begin
			start = 1'b0;
			character = CharW'($urandom);
			@(negedge clk);
		end
		start = 1'b1;
		character = c;
		do @(posedge clk); while (busy);
		if (predict)
			key_schedule(c);
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		start = 1'b0;
		do @(posedge clk); while (schedule_q.size() != 0 || busy);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DurW-1:0] d);
		wait_quiet();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DOT:      durs.dot = d;
			REG_DASH:     durs.dash = d;
			REG_SYM_GAP:  durs.sym_gap = d;
			REG_WORD_GAP: durs.word_gap = d;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("morse_keyer_timing: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		character = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		failed = 1'b0;
		durs = {DOT_RST, DASH_RST, SYM_GAP_RST, WORD_GAP_RST};

		dir_q.push_back(char_row("E", 1'b1, 2'd2, ivl(1'b1, DOT_RST, 1'b0),
			ivl(1'b0, SYM_GAP_RST, 1'b1)));
		dir_q.push_back(char_row("T", 1'b1, 2'd2, ivl(1'b1, DASH_RST, 1'b0),
			ivl(1'b0, SYM_GAP_RST, 1'b1)));
		dir_q.push_back(char_row(CH_SPACE, 1'b1, 2'd1, ivl(1'b0, WORD_GAP_RST, 1'b1), NO_IVL));
		dir_q.push_back(char_row(8'h00, 1'b1, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row(8'hFF, 1'b1, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row(CH_UPPER_A - 1, 1'b1, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row(CH_UPPER_Z + 1, 1'b1, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row(CH_LOWER_A - 1, 1'b1, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row(CH_LOWER_Z + 1, 1'b1, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row(8'h80, 1'b1, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row("7", 1'b1, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row(CH_UPPER_A, 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row(CH_UPPER_Z, 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row(CH_LOWER_A, 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row(CH_LOWER_Z, 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row("Q", 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row("h", 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row("O", 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row("y", 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(cfg_row(REG_DOT, '0));
		dir_q.push_back(cfg_row(REG_DASH, '1));
		dir_q.push_back(cfg_row(REG_SYM_GAP, '0));
		dir_q.push_back(cfg_row(REG_WORD_GAP, '1));
		dir_q.push_back(cfg_row(REG_SPARE, 16'h1234));
		dir_q.push_back(char_row("B", 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row(CH_SPACE, 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row("j", 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(cfg_row(REG_DOT, '1));
		dir_q.push_back(cfg_row(REG_DASH, '0));
		dir_q.push_back(cfg_row(REG_SYM_GAP, '1));
		dir_q.push_back(cfg_row(REG_WORD_GAP, '0));
		dir_q.push_back(char_row("K", 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row(CH_SPACE, 1'b0, 2'd0, NO_IVL, NO_IVL));
		dir_q.push_back(char_row("x", 1'b0, 2'd0, NO_IVL, NO_IVL));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_q[k]) begin
			rw = dir_q[k];
			if (rw.kind == ROW_CFG) begin
				write_reg(rw.idx, rw.data);
			end else begin
				send_char(rw.ch, 24, !rw.typed);
				if (rw.typed && rw.n > 0)
					schedule_q.push_back(rw.r0);
				if (rw.typed && rw.n > 1)
					schedule_q.push_back(rw.r1);
			end
		end

		for (int blk = 0; blk < 6; blk++) begin
			for (int r = REG_DOT; r <= REG_WORD_GAP; r++) begin
				sel = $urandom_range(0, 3);
				val = (sel == 0) ? '0 : (sel == 1) ? '1 : DurW'($urandom);
				write_reg(IdxW'(r), val);
			end
			if ($urandom_range(0, 2) == 0)
				write_reg(IdxW'($urandom_range(REG_WORD_GAP + 1, REG_TOP)), DurW'($urandom));
			idle_pct = (blk < 2) ? 24 : (blk < 4) ? 53 : 0;
			acted = 0;
			while (acted < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					ch = ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) +
						CharW'($urandom_range(0, 25));
				else if (pick < 75)
					ch = CH_SPACE;
				else
					ch = CharW'($urandom);
				acted++;
				send_char(ch, idle_pct, 1'b1);
			end
		end

		wait_quiet();
		if (!failed)
			$display("morse_keyer_timing: match");
		else
			$display("morse_keyer_timing: mismatch");
		$finish;
	end

endmodule
